// ===== src/anagram_checker_macros.svh =====
// Assertion macros shared by the anagram checker RTL.
// No dependencies; assumes clk and rst_n exist in the including module.
`ifndef ANAGRAM_CHECKER_MACROS_SVH
`define ANAGRAM_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ac_pkg.sv =====
// Types and fixed constants for the anagram checker.
// No dependencies; imported by ac_ram users and anagram_checker.
package ac_pkg;

  localparam int SYM_W    = 8;
  localparam int NSYM     = 1 << SYM_W;
  localparam int OPCODE_W = 2;
  localparam int TALLY_W  = SYM_W + 1;   // holds 0 .. NSYM

  typedef enum logic [OPCODE_W-1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_END    = 2'd2
  } op_t;

endpackage

// ===== src/anagram_checker.sv =====
// Anagram checker top level: symbol histogram with signed per-symbol counts.
// Depends on ac_pkg, ac_ram and anagram_checker_macros.svh.
//
//  channel | handshake            | word carries
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_ready  | in_opcode, in_symbol
//  out     | out_valid / out_ready| out_is_anagram, out_too_long
//
// One word is taken per cycle unless an end-of-pair word waits. A word is held
// in the input stage while its counter entry (read from the RAM at accept time)
// is updated and written back; a verdict enters the output register from the
// input stage when its end-of-pair word leaves that stage.
// An end-of-pair word waits in the input stage while the output register
// holds an untaken verdict; symbol words never wait.
// Reset clears the touched bits, tally, lengths and flags at once; the count
// RAM is not cleared, as an entry is only used while its touched bit is set.
`include "anagram_checker_macros.svh"

module anagram_checker #(
  parameter int MAX_LEN = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ac_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [ac_pkg::SYM_W-1:0]     in_symbol,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_anagram,
  output logic                         out_too_long
);

  import ac_pkg::*;

  // Length counters reach MAX_LEN; the difference spans -MAX_LEN .. MAX_LEN.
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int DW = LW + 1;

  // Input stage
  logic                s1_valid_r, s1_valid_nxt;
  logic [OPCODE_W-1:0] s1_op_r;
  logic [SYM_W-1:0]    s1_sym_r;

  // Pair state
  logic [NSYM-1:0]     touched_r, touched_nxt;
  logic [TALLY_W-1:0]  tally_r, tally_nxt;
  logic [LW-1:0]       len1_r, len1_nxt;
  logic [LW-1:0]       len2_r, len2_nxt;
  logic                ovf_r, ovf_nxt;

  // Bypass of the entry written at the edge the next word was read
  logic                fwd_valid_r;
  logic [SYM_W-1:0]    fwd_sym_r;
  logic signed [DW-1:0] fwd_val_r;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_is_anagram_r;
  logic                out_too_long_r;

  // Datapath
  logic                in_acc;
  logic                is_end, end_go;
  logic                is_second, is_sym, len_full, do_cnt;
  logic [LW-1:0]       cur_len;
  logic [DW-1:0]       ram_rdata;
  logic signed [DW-1:0] rd_val, old_val, new_val;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign is_end   = s1_valid_r && (s1_op_r == OP_END);
  assign end_go   = is_end && (!out_valid_r || out_ready);
  // Only an end-of-pair word facing a full output register holds the stage.
  assign in_ready = !is_end || end_go;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Count RAM: read on accept, write back from the input stage
  // ---------------------------------------------------------------------------
  ac_ram #(
    .WIDTH (DW),
    .DEPTH (NSYM)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (do_cnt),
    .wr_addr (s1_sym_r),
    .wr_data (new_val),
    .rd_en   (in_acc),
    .rd_addr (in_symbol),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Symbol update
  // ---------------------------------------------------------------------------
  always_comb begin
    is_second = (s1_op_r == OP_SECOND);
    is_sym    = s1_valid_r && ((s1_op_r == OP_FIRST) || is_second);
    cur_len   = is_second ? len2_r : len1_r;
    len_full  = (cur_len >= LW'(MAX_LEN));
    do_cnt    = is_sym && !len_full;

    // RAM read raced the previous write to the same symbol: take the bypass.
    rd_val  = (fwd_valid_r && (fwd_sym_r == s1_sym_r)) ? fwd_val_r : $signed(ram_rdata);
    old_val = touched_r[s1_sym_r] ? rd_val : '0;
    new_val = is_second ? (old_val - DW'(1)) : (old_val + DW'(1));
  end

  // ---------------------------------------------------------------------------
  // Next pair state
  // ---------------------------------------------------------------------------
  always_comb begin
    touched_nxt = touched_r;
    tally_nxt   = tally_r;
    len1_nxt    = len1_r;
    len2_nxt    = len2_r;
    ovf_nxt     = ovf_r;
    if (s1_valid_r) begin
      unique case (s1_op_r)
        OP_FIRST, OP_SECOND: begin
          if (len_full) begin
            ovf_nxt = 1'b1;
          end else begin
            touched_nxt[s1_sym_r] = 1'b1;
            if (is_second) begin
              len2_nxt = len2_r + LW'(1);
            end else begin
              len1_nxt = len1_r + LW'(1);
            end
            // A step of one: zero to nonzero adds, nonzero to zero removes.
            if (old_val == '0) begin
              tally_nxt = tally_r + TALLY_W'(1);
            end else if (new_val == '0) begin
              tally_nxt = tally_r - TALLY_W'(1);
            end
          end
        end
        OP_END: begin
          if (end_go) begin
            touched_nxt = '0;
            tally_nxt   = '0;
            len1_nxt    = '0;
            len2_nxt    = '0;
            ovf_nxt     = 1'b0;
          end
        end
        default: begin
          // unused opcode: no effect
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (in_ready ? 1'b0 : s1_valid_r);
    out_valid_nxt = end_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      touched_r   <= '0;
      tally_r     <= '0;
      len1_r      <= '0;
      len2_r      <= '0;
      ovf_r       <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      touched_r   <= touched_nxt;
      tally_r     <= tally_nxt;
      len1_r      <= len1_nxt;
      len2_r      <= len2_nxt;
      ovf_r       <= ovf_nxt;
      fwd_valid_r <= do_cnt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_opcode;
      s1_sym_r <= in_symbol;
    end
    if (do_cnt) begin
      fwd_sym_r <= s1_sym_r;
      fwd_val_r <= new_val;
    end
    if (end_go) begin
      out_is_anagram_r <= !ovf_r && (tally_r == '0);
      out_too_long_r   <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_anagram = out_is_anagram_r;
  assign out_too_long   = out_too_long_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `AC_ASSERT_IMP(a_tally_range, 1'b1, tally_r <= TALLY_W'(NSYM), "tally above symbol count")
  `AC_ASSERT_IMP(a_len_range, 1'b1, (len1_r <= LW'(MAX_LEN)) && (len2_r <= LW'(MAX_LEN)),
    "word length above MAX_LEN")
  `AC_ASSERT_IMP(a_ovf_at_limit, ovf_r,
    (len1_r == LW'(MAX_LEN)) || (len2_r == LW'(MAX_LEN)), "overflow below limit")
  `AC_ASSERT_NXT(a_end_clears, end_go,
    (tally_r == '0) && (touched_r == '0) && !ovf_r, "pair state not cleared")
  `AC_ASSERT_IMP(a_verdict_flags, out_valid_r && out_is_anagram_r, !out_too_long_r,
    "anagram verdict with too_long")

endmodule

// ===== src/ac_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module ac_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
